@@ hw/rtl/hmq_pkg.sv @@
// Shared types, constants and codes for the binary min-heap queue.
`default_nettype none

package hmq_pkg;

    // Heap geometry and field widths.
    localparam int HEAP_DEPTH   = 1024;
    localparam int KEY_BITS     = 48;
    localparam int PAYLOAD_BITS = 20;
    localparam int ADDR_BITS    = $clog2(HEAP_DEPTH);
    localparam int COUNT_BITS   = $clog2(HEAP_DEPTH + 1);
    localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

    // Command codes carried in the input beat.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Status codes reported with every result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One stored heap entry.
    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // Input beat.
    typedef struct packed {
        logic                    cmd;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic [KEY_BITS-1:0]     popped_key;
        logic [PAYLOAD_BITS-1:0] popped_payload;
        logic                    popped_valid;
        logic [COUNT_BITS-1:0]   entry_total;
        status_t                 status;
    } result_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_READ,
        S_UP_CMP,
        S_POP_READ,
        S_POP_LOAD,
        S_DN_READ,
        S_DN_CMP,
        S_PLACE,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    load_push;
        logic    rd_pop;
        logic    rd_children;
        logic    pop_load;
        logic    move_up;
        logic    move_down;
        logic    place;
        logic    emit;
        status_t code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic last;
        logic root;
        logic leaf;
        logic up_move;
        logic down_move;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/binary_min_heap_queue.sv @@
// Top level of the binary min-heap priority queue.
//
//   channel   signals              beat moves when
//   --------  -------------------  --------------------------
//   command   start, busy, item    start high while busy low
//   result    done, result         done high (one cycle)
//
// A push climbs at most 10 levels, stopping when a compare stops it or when it
// reaches the root; a pop descends until it reaches a leaf or a compare stops
// it; a pop that empties the heap skips the descent.
// Each level is one read of the entry memory and one compare-and-write.
// An error command (push on full, pop on empty) goes straight to S_FINISH, which raises done.
// Reset clears the count and the controller; the memory keeps no reset state.
// The result beat is shown for one cycle and cannot be stalled.
`default_nettype none

module binary_min_heap_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire hmq_pkg::item_t  item,
    output logic                 done,
    output hmq_pkg::result_t     result
);

    import hmq_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t stat;

    hmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (item.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    hmq_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

`ifndef SYNTHESIS
    // A result beat only appears once the controller is back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // Every accepted command leaves idle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not start");

    // A returned entry always carries an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.popped_valid) |-> (result.status == ST_OK))
        else $error("popped entry with error status");

    // The count never exceeds the heap depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_total <= COUNT_BITS'(HEAP_DEPTH)))
        else $error("entry count beyond depth");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/hmq_ram.sv @@
// Single-write, dual-read memory with registered read data.
`default_nettype none

module hmq_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 68
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ hw/rtl/hmq_datapath.sv @@
// Heap datapath: entry memory, count, position, held entry and result register.
`default_nettype none

module hmq_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hmq_pkg::ctrl_cmd_t ctl,
    input  wire hmq_pkg::item_t     item,
    output hmq_pkg::dp_status_t     stat,
    output hmq_pkg::result_t        result,
    output logic                    done
);

    import hmq_pkg::*;

    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic [COUNT_BITS-1:0]   pos_reg;
    logic [COUNT_BITS-1:0]   pos_next;
    entry_t                  hold_reg;
    entry_t                  hold_next;
    entry_t                  popped_reg;
    entry_t                  popped_next;
    logic                    pvalid_reg;
    logic                    pvalid_next;
    result_t                 result_reg;
    logic                    done_reg;

    logic [COUNT_BITS:0]     child;
    logic [COUNT_BITS:0]     child_right;
    logic [COUNT_BITS:0]     count_ext;
    logic [COUNT_BITS:0]     child_m1;
    logic [COUNT_BITS-1:0]   parent;
    logic [COUNT_BITS-1:0]   parent_m1;
    logic [COUNT_BITS-1:0]   pos_m1;
    logic [COUNT_BITS-1:0]   count_m1;
    logic                    take_right;
    entry_t                  sel;
    logic [COUNT_BITS:0]     sel_pos;

    logic                    we;
    logic [ADDR_BITS-1:0]    waddr;
    entry_t                  wdata;
    logic [ADDR_BITS-1:0]    raddr_a;
    logic [ADDR_BITS-1:0]    raddr_b;
    logic [ENTRY_BITS-1:0]   rdata_a_raw;
    logic [ENTRY_BITS-1:0]   rdata_b_raw;
    entry_t                  rd_a;
    entry_t                  rd_b;

    // Tree arithmetic on one-based positions; slot p lives at address p-1.
    always_comb
    begin
        child       = {pos_reg, 1'b0};
        child_right = child + (COUNT_BITS + 1)'(1);
        child_m1    = child - (COUNT_BITS + 1)'(1);
        count_ext   = {1'b0, count_reg};
        parent      = pos_reg >> 1;
        parent_m1   = parent - COUNT_BITS'(1);
        pos_m1      = pos_reg - COUNT_BITS'(1);
        count_m1    = count_reg - COUNT_BITS'(1);
    end

    // Read address selection.
    always_comb
    begin
        if (ctl.rd_pop)
        begin
            raddr_a = '0;
            raddr_b = count_m1[ADDR_BITS-1:0];
        end
        else if (ctl.rd_children)
        begin
            raddr_a = child_m1[ADDR_BITS-1:0];
            raddr_b = child[ADDR_BITS-1:0];
        end
        else
        begin
            raddr_a = parent_m1[ADDR_BITS-1:0];
            raddr_b = parent_m1[ADDR_BITS-1:0];
        end
    end

    assign rd_a = entry_t'(rdata_a_raw);
    assign rd_b = entry_t'(rdata_b_raw);

    // Smaller child; the right one wins only when strictly smaller.
    always_comb
    begin
        take_right = (child < count_ext) && (rd_b.key < rd_a.key);
        sel        = take_right ? rd_b : rd_a;
        sel_pos    = take_right ? child_right : child;
    end

    // Status toward the controller.
    always_comb
    begin
        stat.full      = (count_reg == COUNT_BITS'(HEAP_DEPTH));
        stat.empty     = (count_reg == '0);
        stat.last      = (count_reg == COUNT_BITS'(1));
        stat.root      = (pos_reg == COUNT_BITS'(1));
        stat.leaf      = (child > count_ext);
        stat.up_move   = (hold_reg.key < rd_a.key);
        stat.down_move = (hold_reg.key > sel.key);
    end

    // Write port: move a parent down, a child up, or drop the held entry in place.
    always_comb
    begin
        we    = ctl.move_up | ctl.move_down | ctl.place;
        waddr = pos_m1[ADDR_BITS-1:0];
        if (ctl.move_up)
        begin
            wdata = rd_a;
        end
        else if (ctl.move_down)
        begin
            wdata = sel;
        end
        else
        begin
            wdata = hold_reg;
        end
    end

    hmq_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (ENTRY_BITS)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (ENTRY_BITS'(wdata)),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a_raw),
        .rdata_b (rdata_b_raw)
    );

    // Next values of count, position, held and popped entries.
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        popped_next = popped_reg;
        pvalid_next = pvalid_reg;
        if (ctl.accept)
        begin
            popped_next = '0;
            pvalid_next = 1'b0;
        end
        if (ctl.load_push)
        begin
            count_next        = count_reg + COUNT_BITS'(1);
            pos_next          = count_reg + COUNT_BITS'(1);
            hold_next.key     = item.key;
            hold_next.payload = item.payload;
        end
        if (ctl.pop_load)
        begin
            popped_next = rd_a;
            pvalid_next = 1'b1;
            hold_next   = rd_b;
            count_next  = count_m1;
            pos_next    = COUNT_BITS'(1);
        end
        if (ctl.move_up)
        begin
            pos_next = parent;
        end
        if (ctl.move_down)
        begin
            pos_next = sel_pos[COUNT_BITS-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pos_reg    <= '0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            pvalid_reg <= pvalid_next;
            done_reg   <= ctl.emit;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        popped_reg <= popped_next;
        if (ctl.emit)
        begin
            result_reg.popped_key     <= popped_reg.key;
            result_reg.popped_payload <= popped_reg.payload;
            result_reg.popped_valid   <= pvalid_reg;
            result_reg.entry_total    <= count_reg;
            result_reg.status         <= ctl.code;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hmq_ctrl.sv @@
// Heap controller: sequences push sift-up and pop sift-down one level at a time.
`default_nettype none

module hmq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                cmd,
    input  wire hmq_pkg::dp_status_t stat,
    output hmq_pkg::ctrl_cmd_t       ctl,
    output logic                     busy
);

    import hmq_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;

    // State and status code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        ctl        = '0;
        ctl.code   = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    code_next  = ST_OK;
                    if (cmd == CMD_PUSH)
                    begin
                        if (stat.full)
                        begin
                            code_next  = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ctl.load_push = 1'b1;
                            state_next    = S_UP_READ;
                        end
                    end
                    else if (stat.empty)
                    begin
                        code_next  = ST_EMPTY;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_POP_READ;
                    end
                end
            end
            S_UP_READ:
            begin
                // Parent address is presented by default.
                state_next = stat.root ? S_PLACE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    ctl.move_up = 1'b1;
                    state_next  = S_UP_READ;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_POP_READ:
            begin
                ctl.rd_pop = 1'b1;
                state_next = S_POP_LOAD;
            end
            S_POP_LOAD:
            begin
                ctl.pop_load = 1'b1;
                state_next   = stat.last ? S_FINISH : S_DN_READ;
            end
            S_DN_READ:
            begin
                if (stat.leaf)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ctl.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (stat.down_move)
                begin
                    ctl.move_down = 1'b1;
                    state_next    = S_DN_READ;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                ctl.place  = 1'b1;
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
            end
            S_FINISH:
            begin
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ sim/tb_binary_min_heap_queue.sv @@
// Self-checking testbench for the binary min-heap queue: directed and random command beats.

module tb_binary_min_heap_queue;

    import hmq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_SHOWN = 10;
    localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
    localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_MAX = {PAYLOAD_BITS{1'b1}};

    // A queued command beat, optionally held back until the queue has drained.
    typedef struct {
        item_t beat;
        bit    drain_first;
    } pending_cmd_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    pending_cmd_t pending_cmds[$];
    result_t      expected_results[$];

    // Shadow copy of the heap, 1-based like the hardware array.
    logic [KEY_BITS-1:0]     shadow_key[1:HEAP_DEPTH];
    logic [PAYLOAD_BITS-1:0] shadow_payload[1:HEAP_DEPTH];
    int unsigned             shadow_count;

    // Entry count seen by the stimulus builder while it plans command beats.
    int unsigned planned_count;

    bit          beat_taken;
    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    binary_min_heap_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one command beat to the shadow heap and return the result it should report.
    function automatic result_t heap_apply(item_t beat);
        result_t                 res;
        int unsigned             pos;
        int unsigned             child;
        logic [KEY_BITS-1:0]     moving_key;
        logic [PAYLOAD_BITS-1:0] moving_payload;
        res = '0;
        res.status = ST_OK;
        if (beat.cmd == CMD_PUSH)
        begin
            if (shadow_count >= HEAP_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                // Climb while strictly smaller than the parent.
                shadow_count++;
                pos = shadow_count;
                while (pos > 1 && beat.key < shadow_key[pos >> 1])
                begin
                    shadow_key[pos] = shadow_key[pos >> 1];
                    shadow_payload[pos] = shadow_payload[pos >> 1];
                    pos = pos >> 1;
                end
                shadow_key[pos] = beat.key;
                shadow_payload[pos] = beat.payload;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.popped_key = shadow_key[1];
            res.popped_payload = shadow_payload[1];
            res.popped_valid = 1'b1;
            moving_key = shadow_key[shadow_count];
            moving_payload = shadow_payload[shadow_count];
            shadow_count--;
            // Descend while strictly larger than the smaller child; ties go left.
            pos = 1;
            if (shadow_count > 0)
            begin
                child = 2;
                while (child <= shadow_count)
                begin
                    if (child < shadow_count && shadow_key[child + 1] < shadow_key[child])
                        child++;
                    if (moving_key > shadow_key[child])
                    begin
                        shadow_key[pos] = shadow_key[child];
                        shadow_payload[pos] = shadow_payload[child];
                        pos = child;
                        child = pos << 1;
                    end
                    else
                    begin
                        break;
                    end
                end
                shadow_key[pos] = moving_key;
                shadow_payload[pos] = moving_payload;
            end
        end
        res.entry_total = COUNT_BITS'(shadow_count);
        return res;
    endfunction

    // Key mix: dense small values for ties, extremes, and full-width random.
    function automatic logic [KEY_BITS-1:0] random_key();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: return KEY_BITS'($urandom_range(0, 15));
            2: return ($urandom_range(0, 1) == 1) ? KEY_MAX : '0;
            default: return wide[KEY_BITS-1:0];
        endcase
    endfunction

    // Queue a command beat and track the entry count it leaves behind.
    function automatic void queue_cmd(logic cmd, logic [KEY_BITS-1:0] key,
                                      logic [PAYLOAD_BITS-1:0] payload, bit drain_first);
        pending_cmd_t pc;
        pc.beat.cmd = cmd;
        pc.beat.key = key;
        pc.beat.payload = payload;
        pc.drain_first = drain_first;
        pending_cmds.push_back(pc);
        if (cmd == CMD_PUSH && planned_count < HEAP_DEPTH)
            planned_count++;
        else if (cmd == CMD_POP && planned_count > 0)
            planned_count--;
    endfunction

    // Random push with random content; pops also carry random, ignored fields.
    function automatic void queue_random(logic cmd, bit drain_first);
        queue_cmd(cmd, random_key(), PAYLOAD_BITS'($urandom), drain_first);
    endfunction

    // Driver: new beats are presented at the falling edge, in bursts with gaps.
    always @(negedge clk)
    begin : drive_proc
        logic         next_start;
        item_t        next_item;
        pending_cmd_t pc;
        next_start = start;
        next_item = item;
        if (rst_n)
        begin
            if (start && beat_taken)
            begin
                next_start = 1'b0;
                beat_taken = 1'b0;
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain_first && expected_results.size() > 0))
                begin
                    pc = pending_cmds.pop_front();
                    next_item = pc.beat;
                    next_start = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // Pick the next burst; some run long with no gap at all.
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(20, 60);
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(0, 8);
                            gap_left = $urandom_range(1, 30);
                        end
                    end
                end
            end
        end
        start <= next_start;
        item <= next_item;
    end

    // Monitor: accepted beats feed the shadow heap, result beats are checked in order.
    always @(posedge clk)
    begin : monitor_proc
        result_t want;
        bit      differs;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("Unexpected result beat at cycle %0d: key %h payload %h",
                                 cycle_count, result.popped_key, result.popped_payload);
                end
                else
                begin
                    want = expected_results.pop_front();
                    differs = (result.popped_key !== want.popped_key) ||
                              (result.popped_payload !== want.popped_payload) ||
                              (result.popped_valid !== want.popped_valid) ||
                              (result.entry_total !== want.entry_total) ||
                              (result.status !== want.status);
                    if (differs)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                        begin
                            $display("Mismatch at cycle %0d", cycle_count);
                            $display("  expected key %h payload %h valid %b total %0d status %0d",
                                     want.popped_key, want.popped_payload, want.popped_valid,
                                     want.entry_total, want.status);
                            $display("  actual   key %h payload %h valid %b total %0d status %0d",
                                     result.popped_key, result.popped_payload,
                                     result.popped_valid, result.entry_total, result.status);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(heap_apply(item));
                beat_taken = 1'b1;
            end
        end
    end

    // Stimulus build, reset, and end of run.
    initial
    begin
        int unsigned push_weight;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        beat_taken = 1'b0;
        gap_left = 0;
        burst_left = 0;
        mismatch_count = 0;
        cycle_count = 0;
        shadow_count = 0;
        planned_count = 0;

        // Directed: empty pop, key and payload extremes, ties on both ends, drain.
        queue_cmd(CMD_POP, KEY_MAX, PAYLOAD_MAX, 1'b0);
        queue_cmd(CMD_PUSH, '0, '0, 1'b0);
        queue_cmd(CMD_PUSH, KEY_MAX, PAYLOAD_MAX, 1'b0);
        queue_cmd(CMD_PUSH, KEY_MAX, 20'h55555, 1'b0);
        queue_cmd(CMD_PUSH, '0, PAYLOAD_MAX, 1'b0);
        queue_cmd(CMD_PUSH, 48'h8000_0000_0000, 20'h80000, 1'b0);
        queue_cmd(CMD_PUSH, 48'h7FFF_FFFF_FFFF, 20'h7FFFF, 1'b0);
        queue_cmd(CMD_PUSH, 48'h1, 20'h1, 1'b0);
        queue_cmd(CMD_PUSH, 48'h7, 20'h00001, 1'b0);
        queue_cmd(CMD_PUSH, 48'h7, 20'h00002, 1'b0);
        queue_cmd(CMD_PUSH, 48'h7, 20'h00003, 1'b0);
        queue_cmd(CMD_PUSH, 48'hAAAA_AAAA_AAAA, 20'hAAAAA, 1'b0);
        while (planned_count > 0)
            queue_cmd(CMD_POP, 48'h5555_5555_5555, 20'h55555, 1'b0);
        queue_cmd(CMD_POP, '0, '0, 1'b0);

        // Random mix: push bias shifts per segment so the heap grows and shrinks.
        for (int seg = 0; seg < 4; seg++)
        begin
            push_weight = (seg % 2 == 0) ? 70 : 35;
            for (int n = 0; n < 30; n++)
                queue_random(($urandom_range(1, 100) <= push_weight) ? CMD_PUSH : CMD_POP,
                             $urandom_range(0, 49) == 0);
        end

        // Fill to capacity, push into a full heap, and work near the top.
        queue_random(CMD_PUSH, 1'b1);
        while (planned_count < HEAP_DEPTH)
            queue_random(CMD_PUSH, 1'b0);
        for (int n = 0; n < 3; n++)
            queue_random(CMD_PUSH, 1'b0);
        for (int n = 0; n < 20; n++)
            queue_random(($urandom_range(0, 1) == 1) ? CMD_PUSH : CMD_POP, 1'b0);

        // Pop a run of minimums out of the large heap for deep sift-downs.
        for (int n = 0; n < 30; n++)
            queue_random(CMD_POP, 1'b0);
        queue_random(CMD_POP, 1'b1);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every beat is sent and every result has come back.
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
